[rtl/core/quoted_token_splitter_macros.svh]
// assertion helpers used by the checker
`ifndef QUOTED_TOKEN_SPLITTER_MACROS_SVH
`define QUOTED_TOKEN_SPLITTER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define QTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qts assertion failed");

// next-cycle implication, disabled while reset is asserted
`define QTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qts assertion failed");

`endif

[rtl/core/qts_pkg.sv]
package qts_pkg;

  // default buffer size in bytes
  localparam int BUFFER_BYTES_DEF = 4096;

  // fixed field widths
  localparam int OFF_W = 12;
  localparam int LEN_W = 13;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  // register indexes
  localparam logic [1:0] REG_PLAIN_LOW  = 2'd0;
  localparam logic [1:0] REG_PLAIN_HIGH = 2'd1;
  localparam logic [1:0] REG_POINT_LOW  = 2'd2;
  localparam logic [1:0] REG_POINT_HIGH = 2'd3;

  // characters with special meaning
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_BS  = 8'h5C;

  // result kinds
  localparam logic KIND_TOKEN = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_beat_t;

  typedef struct packed {
    logic             kind;
    logic [OFF_W-1:0] token_offset;
    logic [LEN_W-1:0] token_length;
    logic             run_last;
  } out_beat_t;

endpackage

[rtl/core/quoted_token_splitter.sv]
// path: input beat, then scan stage register, then output register for its results
// throughput: one byte per cycle while out_ready_i is high and each byte yields at most
//   one result; a byte that yields n results (n up to 3) holds the scan stage until
//   the single output register has drained them, one result beat per cycle when ready
// reset: rst_ni is asynchronous, active low; clears the scanner state, the
//   separator bitmaps and all valid flags; no clearing pass is needed
module quoted_token_splitter #(
  parameter int BUFFER_BYTES = qts_pkg::BUFFER_BYTES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // byte input
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  qts_pkg::in_beat_t         in_data_i,
  // result output
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output qts_pkg::out_beat_t        out_data_o,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [qts_pkg::ADDR_W-1:0] paddr,
  input  logic [qts_pkg::DATA_W-1:0] pwdata,
  output logic [qts_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);

  localparam int PW = $clog2(BUFFER_BYTES + 1);
  localparam int XW = (PW + 1 > qts_pkg::LEN_W) ? PW + 1 : qts_pkg::LEN_W;
  localparam logic [PW-1:0] BB_P   = PW'(BUFFER_BYTES);
  localparam logic [XW-1:0] MAXOFF = XW'(BUFFER_BYTES - 1);

  // separator bitmaps
  logic [63:0] plain_lo_q, plain_hi_q, point_lo_q, point_hi_q;

  // input skid and scan stage
  logic               sk_v_q, iv_q;
  qts_pkg::in_beat_t  sk_q, in_q;

  // scanner state
  logic [PW-1:0] pos_q, tb_q;
  logic          skip_q, inq_q, qd_q;
  logic [7:0]    first_q, prev_q;
  logic [PW-1:0] pos_d, tb_d;
  logic          skip_d, inq_d, qd_d;
  logic [7:0]    first_d, prev_d;

  // result group register
  logic               gv_q;
  logic [1:0]         gcnt_q, gidx_q;
  qts_pkg::out_beat_t slot_q [3];
  qts_pkg::out_beat_t slot_d [3];
  logic [2:0]         n_res;

  logic grp_free, consume, in_acc, cfg_wr, in_load;

  // saturating increment of a position
  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
    sat_inc = (v < BB_P) ? v + PW'(1) : BB_P;
  endfunction

  // offsets clamp to the last buffer byte
  function automatic logic [qts_pkg::OFF_W-1:0] clamp_off(input logic [XW-1:0] o);
    logic [XW-1:0] c;
    begin
      c = (o > MAXOFF) ? MAXOFF : o;
      clamp_off = c[qts_pkg::OFF_W-1:0];
    end
  endfunction

  // token descriptor with quote stripping
  function automatic qts_pkg::out_beat_t make_tok(input logic [PW-1:0] b,
                                                  input logic [PW-1:0] e,
                                                  input logic [7:0]    f,
                                                  input logic [7:0]    l);
    logic [XW-1:0] len;
    logic [XW-1:0] off;
    logic          strip;
    begin
      len   = XW'(e) - XW'(b);
      strip = (len >= XW'(2)) && (f == l) && ((f == qts_pkg::CH_DQ) || (f == qts_pkg::CH_SQ));
      off   = strip ? XW'(b) + XW'(1) : XW'(b);
      if (strip) len = len - XW'(2);
      make_tok.kind         = qts_pkg::KIND_TOKEN;
      make_tok.token_offset = clamp_off(off);
      make_tok.token_length = len[qts_pkg::LEN_W-1:0];
      make_tok.run_last     = 1'b0;
    end
  endfunction

  // handshakes
  assign in_ready_o  = !sk_v_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign grp_free    = !gv_q || (out_ready_i && (gidx_q == gcnt_q - 2'd1));
  assign consume     = iv_q && grp_free;
  assign in_load     = !iv_q || consume;
  assign out_valid_o = gv_q;
  assign out_data_o  = slot_q[gidx_q];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[4:3])
      qts_pkg::REG_PLAIN_LOW:  prdata = plain_lo_q;
      qts_pkg::REG_PLAIN_HIGH: prdata = plain_hi_q;
      qts_pkg::REG_POINT_LOW:  prdata = point_lo_q;
      qts_pkg::REG_POINT_HIGH: prdata = point_hi_q;
      default:                 prdata = '0;
    endcase
  end

  // scan one byte: state update and result candidates
  always_comb begin
    logic [7:0]            c;
    logic                  lead, prot, is_plain, is_point, sep;
    logic [7:0]            fc;
    logic [PW-1:0]         idx, tb_a, pos_a;
    logic [127:0]          pmap, tmap;
    qts_pkg::out_beat_t    cand [4];
    logic [3:0]            cv;
    logic [2:0]            n;
    c        = in_q.data_byte;
    idx      = pos_q;
    pmap     = {plain_hi_q, plain_lo_q};
    tmap     = {point_hi_q, point_lo_q};
    lead     = ((c >= 8'h81) && (c <= 8'h9F)) || ((c >= 8'hE0) && (c <= 8'hFC));
    prot     = lead || (c == qts_pkg::CH_BS);
    is_plain = (c == qts_pkg::CH_NUL) || (!c[7] && pmap[c[6:0]]);
    is_point = !c[7] && tmap[c[6:0]];
    fc       = (idx == tb_q) ? c : first_q;
    skip_d   = skip_q;
    inq_d    = inq_q;
    qd_d     = qd_q;
    sep      = 1'b0;
    cv       = '0;

    // quote and protection tracking
    if (skip_q) begin
      skip_d = 1'b0;
    end else if (inq_q) begin
      if (prot) skip_d = 1'b1;
      else if (c == (qd_q ? qts_pkg::CH_DQ : qts_pkg::CH_SQ)) inq_d = 1'b0;
    end else if (prot) begin
      skip_d = 1'b1;
    end else if ((c == qts_pkg::CH_DQ) || (c == qts_pkg::CH_SQ)) begin
      inq_d = 1'b1;
      qd_d  = (c == qts_pkg::CH_DQ);
    end else if (is_plain) begin
      sep   = 1'b1;
      cv[0] = idx > tb_q;
    end else if (is_point) begin
      sep   = 1'b1;
      cv[0] = idx > tb_q;
      cv[1] = 1'b1;
    end

    tb_a  = sep ? sat_inc(idx) : tb_q;
    pos_a = sat_inc(idx);

    // candidates in emission order
    cand[0] = make_tok(tb_q, idx, fc, prev_q);
    cand[1].kind         = qts_pkg::KIND_TOKEN;
    cand[1].token_offset = clamp_off(XW'(idx));
    cand[1].token_length = qts_pkg::LEN_W'(1);
    cand[1].run_last     = 1'b0;
    cand[2] = make_tok(tb_a, pos_a, fc, c);
    cand[3].kind         = qts_pkg::KIND_END;
    cand[3].token_offset = '0;
    cand[3].token_length = '0;
    cand[3].run_last     = 1'b0;
    cv[2] = in_q.end_of_buffer && (pos_a > tb_a);
    cv[3] = in_q.end_of_buffer;

    // compact the valid candidates into the group slots
    n = '0;
    for (int i = 0; i < 3; i++) slot_d[i] = cand[3];
    for (int i = 0; i < 4; i++) begin
      if (cv[i] && (n < 3'd3)) begin
        slot_d[n[1:0]] = cand[i];
        n = n + 3'd1;
      end
    end
    if (n != 3'd0) slot_d[2'(n - 3'd1)].run_last = 1'b1;
    n_res = n;

    // next state, back to reset at end of buffer
    pos_d   = pos_a;
    tb_d    = tb_a;
    first_d = fc;
    prev_d  = c;
    if (in_q.end_of_buffer) begin
      pos_d   = '0;
      tb_d    = '0;
      first_d = '0;
      prev_d  = '0;
      skip_d  = 1'b0;
      inq_d   = 1'b0;
      qd_d    = 1'b0;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plain_lo_q <= '0;
      plain_hi_q <= '0;
      point_lo_q <= '0;
      point_hi_q <= '0;
      sk_v_q     <= 1'b0;
      iv_q       <= 1'b0;
      pos_q      <= '0;
      tb_q       <= '0;
      skip_q     <= 1'b0;
      inq_q      <= 1'b0;
      qd_q       <= 1'b0;
      first_q    <= '0;
      prev_q     <= '0;
      gv_q       <= 1'b0;
      gcnt_q     <= '0;
      gidx_q     <= '0;
    end else begin
      // register writes
      if (cfg_wr) begin
        unique case (paddr[4:3])
          qts_pkg::REG_PLAIN_LOW:  plain_lo_q <= pwdata;
          qts_pkg::REG_PLAIN_HIGH: plain_hi_q <= pwdata;
          qts_pkg::REG_POINT_LOW:  point_lo_q <= pwdata;
          qts_pkg::REG_POINT_HIGH: point_hi_q <= pwdata;
          default: ;
        endcase
      end

      // input skid and scan stage valid flags
      if (in_load) begin
        if (sk_v_q) begin
          iv_q   <= 1'b1;
          sk_v_q <= 1'b0;
        end else begin
          iv_q <= in_acc;
        end
      end else if (in_acc) begin
        sk_v_q <= 1'b1;
      end

      // scanner state
      if (consume) begin
        pos_q   <= pos_d;
        tb_q    <= tb_d;
        skip_q  <= skip_d;
        inq_q   <= inq_d;
        qd_q    <= qd_d;
        first_q <= first_d;
        prev_q  <= prev_d;
      end

      // result group drain and load
      if (consume && (n_res != 3'd0)) begin
        gv_q   <= 1'b1;
        gcnt_q <= n_res[1:0];
        gidx_q <= '0;
      end else if (gv_q && out_ready_i) begin
        if (gidx_q == gcnt_q - 2'd1) gv_q <= 1'b0;
        else gidx_q <= gidx_q + 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      if (sk_v_q) in_q <= sk_q;
      else if (in_acc) in_q <= in_data_i;
    end else if (in_acc) begin
      sk_q <= in_data_i;
    end
    if (consume && (n_res != 3'd0)) begin
      for (int i = 0; i < 3; i++) slot_q[i] <= slot_d[i];
    end
  end

endmodule

[rtl/core/qts_checker.sv]
`include "quoted_token_splitter_macros.svh"

module qts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input qts_pkg::out_beat_t out_data_o,
  input logic               pready
);

  // a stalled result beat holds
  `QTS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // the rest of a byte's results follows without a gap
  `QTS_ASSERT_NEXT(a_group_cont, clk_i, rst_ni, out_valid_o && out_ready_i && !out_data_o.run_last, out_valid_o)

  // end marker closes its byte's results and carries no token
  `QTS_ASSERT_NOW(a_end_marker, clk_i, rst_ni, out_valid_o && (out_data_o.kind == qts_pkg::KIND_END), out_data_o.run_last && (out_data_o.token_offset == '0) && (out_data_o.token_length == '0))

  // configuration port never stalls
  `QTS_ASSERT_NOW(a_pready, clk_i, rst_ni, 1'b1, pready)

endmodule

bind quoted_token_splitter qts_checker u_qts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int BUF_BYTES   = qts_pkg::BUFFER_BYTES_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;

  // commonly used separator sets
  localparam logic [63:0] WS_PLAIN   = (64'd1 << 32) | (64'd1 << 9) | (64'd1 << 10) |
                                       (64'd1 << 44);
  localparam logic [63:0] PUNCT_LOW  = (64'd1 << 59) | (64'd1 << 40) | (64'd1 << 41) |
                                       (64'd1 << 61) | (64'd1 << 32);
  localparam logic [63:0] DEL_PLAIN  = 64'd1 << 63;
  localparam logic [63:0] AT_POINT   = 64'd1;
  localparam logic [63:0] ALL_ONES   = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  qts_pkg::in_beat_t  in_beat  = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  qts_pkg::out_beat_t out_beat;

  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [qts_pkg::ADDR_W-1:0]  paddr   = '0;
  logic [qts_pkg::DATA_W-1:0]  pwdata  = '0;
  logic [qts_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  // shadow of the separator registers
  logic [63:0] plain_lo = '0;
  logic [63:0] plain_hi = '0;
  logic [63:0] point_lo = '0;
  logic [63:0] point_hi = '0;

  // shadow of the scanner state
  int         scan_pos   = 0;
  int         tok_begin  = 0;
  bit         skip_next  = 1'b0;
  bit         in_quote   = 1'b0;
  bit         quote_dq   = 1'b0;
  logic [7:0] tok_first  = '0;
  logic [7:0] prev_byte  = '0;

  // descriptors of one byte, then the queue of descriptors still due
  qts_pkg::out_beat_t staged[3];
  int                 staged_n;
  qts_pkg::out_beat_t pending_tokens[$];

  int  error_count = 0;
  int  bytes_sent  = 0;
  int  cycle_count = 0;
  int  stall_left  = 0;
  bit  src_quiet   = 1'b0;
  bit  sink_quiet  = 1'b0;

  always #10 clk = ~clk;

  quoted_token_splitter i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_beat),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result sink with random stalls, mostly short
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_quiet || $urandom_range(0, 99) < 65) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 9) != 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(5, 20);
    end
  end

  // compare each result beat with the oldest predicted descriptor
  always @(posedge clk) begin : check_results
    qts_pkg::out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected result kind %0d offset %0d length %0d last %0d", $time,
                 out_beat.kind, out_beat.token_offset, out_beat.token_length,
                 out_beat.run_last);
        error_count++;
      end else begin
        want = pending_tokens.pop_front();
        if (out_beat.kind !== want.kind || out_beat.token_offset !== want.token_offset ||
            out_beat.token_length !== want.token_length ||
            out_beat.run_last !== want.run_last) begin
          $display("%0t: mismatch expected kind %0d offset %0d length %0d last %0d", $time,
                   want.kind, want.token_offset, want.token_length, want.run_last);
          $display("%0t:          actual   kind %0d offset %0d length %0d last %0d", $time,
                   out_beat.kind, out_beat.token_offset, out_beat.token_length,
                   out_beat.run_last);
          error_count++;
        end
      end
    end
  end

  function automatic bit is_lead_byte(input logic [7:0] c);
    return (c >= 8'h81 && c <= 8'h9F) || (c >= 8'hE0 && c <= 8'hFC);
  endfunction

  // only 7-bit characters can be separators
  function automatic bit in_sep_map(input logic [63:0] lo, input logic [63:0] hi,
                                    input logic [7:0] c);
    if (c[7]) return 1'b0;
    return c[6] ? hi[c[5:0]] : lo[c[5:0]];
  endfunction

  function automatic int sat_inc(input int v);
    return (v < BUF_BYTES) ? v + 1 : BUF_BYTES;
  endfunction

  function automatic void emit(input logic kind, input int off, input int len);
    if (off > BUF_BYTES - 1) off = BUF_BYTES - 1;
    staged[staged_n].kind         = kind;
    staged[staged_n].token_offset = off[qts_pkg::OFF_W-1:0];
    staged[staged_n].token_length = len[qts_pkg::LEN_W-1:0];
    staged[staged_n].run_last     = 1'b0;
    staged_n++;
  endfunction

  // token from..upto, without its quotes when framed by the same quote
  function automatic void emit_token(input int from, input int upto, input logic [7:0] last_ch);
    int len;
    len = upto - from;
    if (len <= 0) return;
    if (len >= 2 && tok_first == last_ch &&
        (tok_first == qts_pkg::CH_DQ || tok_first == qts_pkg::CH_SQ))
      emit(qts_pkg::KIND_TOKEN, from + 1, len - 2);
    else
      emit(qts_pkg::KIND_TOKEN, from, len);
  endfunction

  // advance the shadow scanner by one byte and queue its descriptors
  function automatic void scan_byte(input qts_pkg::in_beat_t b);
    logic [7:0] c;
    int         idx;
    int         k;
    c        = b.data_byte;
    idx      = scan_pos;
    staged_n = 0;
    if (idx == tok_begin) tok_first = c;

    if (skip_next) begin
      skip_next = 1'b0;
    end else if (in_quote) begin
      if (is_lead_byte(c) || c == qts_pkg::CH_BS) skip_next = 1'b1;
      else if (c == (quote_dq ? qts_pkg::CH_DQ : qts_pkg::CH_SQ)) in_quote = 1'b0;
    end else if (is_lead_byte(c) || c == qts_pkg::CH_BS) begin
      skip_next = 1'b1;
    end else if (c == qts_pkg::CH_DQ || c == qts_pkg::CH_SQ) begin
      in_quote = 1'b1;
      quote_dq = (c == qts_pkg::CH_DQ);
    end else if (c == qts_pkg::CH_NUL || in_sep_map(plain_lo, plain_hi, c)) begin
      emit_token(tok_begin, idx, prev_byte);
      tok_begin = sat_inc(idx);
    end else if (in_sep_map(point_lo, point_hi, c)) begin
      emit_token(tok_begin, idx, prev_byte);
      emit(qts_pkg::KIND_TOKEN, idx, 1);
      tok_begin = sat_inc(idx);
    end

    prev_byte = c;
    scan_pos  = sat_inc(idx);

    // trailing token, end marker, back to the start state
    if (b.end_of_buffer) begin
      emit_token(tok_begin, scan_pos, prev_byte);
      emit(qts_pkg::KIND_END, 0, 0);
      scan_pos  = 0;
      tok_begin = 0;
      skip_next = 1'b0;
      in_quote  = 1'b0;
      quote_dq  = 1'b0;
      tok_first = '0;
      prev_byte = '0;
    end

    if (staged_n > 0) staged[staged_n - 1].run_last = 1'b1;
    for (k = 0; k < staged_n; k++) pending_tokens.push_back(staged[k]);
  endfunction

  function automatic int pick_gap();
    int r;
    if (src_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic logic [7:0] lead_byte();
    if ($urandom_range(0, 1) != 0) return 8'($urandom_range(8'h81, 8'h9F));
    return 8'($urandom_range(8'hE0, 8'hFC));
  endfunction

  function automatic logic [7:0] any_separator();
    case ($urandom_range(0, 10))
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return 8'h0A;
      3:       return 8'h2C;
      4:       return 8'h3B;
      5:       return 8'h28;
      6:       return 8'h29;
      7:       return 8'h3D;
      8:       return 8'h40;
      9:       return 8'h7F;
      default: return qts_pkg::CH_NUL;
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'(8'h61 + $urandom_range(0, 25));
    if (r < 45) return 8'h20;
    if (r < 55) return any_separator();
    if (r < 63) return ($urandom_range(0, 1) != 0) ? qts_pkg::CH_DQ : qts_pkg::CH_SQ;
    if (r < 68) return qts_pkg::CH_BS;
    if (r < 75) return lead_byte();
    if (r < 78) return qts_pkg::CH_NUL;
    return 8'($urandom_range(0, 255));
  endfunction

  // one input beat; valid stays up across back-to-back beats
  task automatic send_byte(input logic [7:0] b, input logic eob);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid               <= 1'b1;
    in_beat.data_byte      <= b;
    in_beat.end_of_buffer  <= eob;
    do @(posedge clk); while (!in_ready);
    scan_byte(in_beat);
    bytes_sent++;
  endtask

  task automatic send_text(input logic [7:0] text[$]);
    int i;
    for (i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
  endtask

  // let every due descriptor arrive, then a few more cycles
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      qts_pkg::REG_PLAIN_LOW:  plain_lo = value;
      qts_pkg::REG_PLAIN_HIGH: plain_hi = value;
      qts_pkg::REG_POINT_LOW:  point_lo = value;
      qts_pkg::REG_POINT_HIGH: point_hi = value;
      default: ;
    endcase
  endtask

  task automatic set_separators(input logic [63:0] plo, input logic [63:0] phi,
                                input logic [63:0] qlo, input logic [63:0] qhi);
    wait_idle();
    write_reg(qts_pkg::REG_PLAIN_LOW, plo);
    write_reg(qts_pkg::REG_PLAIN_HIGH, phi);
    write_reg(qts_pkg::REG_POINT_LOW, qlo);
    write_reg(qts_pkg::REG_POINT_HIGH, qhi);
  endtask

  // words, separators, quoted spans and escapes with random content
  task automatic send_random_buffer();
    logic [7:0] text[$];
    logic [7:0] q;
    int         pieces;
    int         p;
    int         k;
    int         n;
    src_quiet  = ($urandom_range(0, 4) == 0);
    sink_quiet = src_quiet;
    pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
    for (p = 0; p < pieces; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++) text.push_back(8'(8'h61 + $urandom_range(0, 25)));
        end
        3, 4: text.push_back(any_separator());
        5: begin
          // quoted span, usually closed
          q = ($urandom_range(0, 1) != 0) ? qts_pkg::CH_DQ : qts_pkg::CH_SQ;
          text.push_back(q);
          n = $urandom_range(0, 5);
          for (k = 0; k < n; k++) text.push_back(pick_byte());
          if ($urandom_range(0, 4) != 0) text.push_back(q);
        end
        6: begin
          text.push_back(qts_pkg::CH_BS);
          text.push_back(pick_byte());
        end
        7: begin
          text.push_back(lead_byte());
          text.push_back(pick_byte());
        end
        8:       text.push_back(pick_byte());
        default: text.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    send_text(text);
  endtask

  task automatic random_phase(input int n);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n) send_random_buffer();
  endtask

  // hand-picked buffers for quoting, escapes and separator corner cases
  task automatic test_directed();
    logic [7:0] text[$];
    set_separators(WS_PLAIN, DEL_PLAIN, PUNCT_LOW, AT_POINT);
    // quoted span with space, escaped space, protected point separator,
    // NUL, high bytes, unclosed quote at the end
    text = '{8'h22, 8'h61, 8'h20, 8'h22, 8'h20, 8'h5C, 8'h20, 8'h3B, 8'h81, 8'h3B,
             8'h00, 8'hFF, 8'hFD, 8'h27};
    send_text(text);
    // lone quote is never stripped
    text = '{8'h22};
    send_text(text);
    // empty quoted token
    text = '{8'h27, 8'h27};
    send_text(text);
    // three descriptors from the last byte
    text = '{8'h78, 8'h3B};
    send_text(text);
    // unclosed quote ending on an escaped copy of the opening quote
    text = '{8'h22, 8'h61, 8'h5C, 8'h22};
    send_text(text);
    // escape on the last byte
    text = '{8'h61, 8'h62, 8'h5C};
    send_text(text);
    // separators from the upper bitmaps
    text = '{8'h40, 8'h7F};
    send_text(text);
  endtask

  // random buffers under several separator settings, extremes included
  task automatic test_random_settings();
    set_separators('0, '0, '0, '0);
    random_phase(56);
    set_separators(ALL_ONES, ALL_ONES, '0, '0);
    random_phase(56);
    set_separators('0, '0, ALL_ONES, ALL_ONES);
    random_phase(56);
    set_separators(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    random_phase(56);
    set_separators(WS_PLAIN, DEL_PLAIN, PUNCT_LOW, AT_POINT);
    random_phase(56);
    set_separators({$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
    random_phase(56);
    set_separators({$urandom, $urandom} & {$urandom, $urandom},
                   {$urandom, $urandom} & {$urandom, $urandom},
                   {$urandom, $urandom} & {$urandom, $urandom},
                   {$urandom, $urandom} & {$urandom, $urandom});
    random_phase(56);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_settings();
    wait_idle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
